// ----- rtl/hcs_pkg.sv -----
`default_nettype none
package hcs_pkg;

  localparam int HCS_MAX_VERTICES = 16;
  localparam int HCS_MAX_REPORTS  = 63;
  localparam logic [4:0] VCOUNT_RESET = 5'd16;

  localparam logic [1:0] FUNC_ADD_EDGE = 2'd0;
  localparam logic [1:0] FUNC_CLEAR    = 2'd1;
  localparam logic [1:0] FUNC_SEARCH   = 2'd2;
  localparam logic [1:0] FUNC_UNUSED   = 2'd3;

  localparam logic [1:0] KIND_CYCLE  = 2'd0;
  localparam logic [1:0] KIND_FINISH = 2'd1;
  localparam logic [1:0] KIND_ACK    = 2'd2;

  typedef struct packed {
    logic [1:0] func;
    logic [3:0] edge_u;
    logic [3:0] edge_v;
    logic [3:0] start_vertex;
  } hcs_cmd_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] cycle_path;
    logic        any_found;
    logic        report_overflow;
    logic        last;
  } hcs_result_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EDGE_RDU,
    ST_EDGE_WRU,
    ST_EDGE_RDV,
    ST_EDGE_WRV,
    ST_ACK,
    ST_SRCH_RD,
    ST_SRCH_INIT,
    ST_ROW_WAIT,
    ST_EXPAND,
    ST_POP_WAIT,
    ST_PACK_RD,
    ST_PACK_GET,
    ST_REPORT,
    ST_FINISH
  } hcs_state_t;

endpackage
`default_nettype wire

// ----- rtl/hcs_if.sv -----
`default_nettype none
interface hcs_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [3:0] edge_u;
  logic [3:0] edge_v;
  logic [3:0] start_vertex;
  modport source(output valid, func, edge_u, edge_v, start_vertex, input ready);
  modport sink(input valid, func, edge_u, edge_v, start_vertex, output ready);
endinterface

interface hcs_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [63:0] cycle_path;
  logic        any_found;
  logic        report_overflow;
  logic        last;
  modport source(output valid, kind, cycle_path, any_found, report_overflow, last,
                 input ready);
  modport sink(input valid, kind, cycle_path, any_found, report_overflow, last,
               output ready);
endinterface
`default_nettype wire

// ----- rtl/hcs_engine.sv -----
`default_nettype none
module hcs_engine
  import hcs_pkg::*;
#(
  parameter int MAX_VERTICES = HCS_MAX_VERTICES,
  parameter int MAX_REPORTS  = HCS_MAX_REPORTS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [4:0]  vertex_count,
  input  wire logic        cmd_valid,
  output logic             cmd_ready,
  input  wire hcs_cmd_t    cmd,
  output logic             res_valid,
  input  wire logic        res_ready,
  output hcs_result_t      res
);

  localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int NW = $clog2(MAX_VERTICES + 1);
  localparam int RW = $clog2(MAX_REPORTS + 1);
  localparam logic [NW-1:0] NMAX = NW'(MAX_VERTICES);
  localparam logic [RW-1:0] RMAX = RW'(MAX_REPORTS);

  logic [MAX_VERTICES-1:0] adj_mem [MAX_VERTICES];
  logic [VW-1:0]           path_mem [MAX_VERTICES];
  logic [NW-1:0]           cur_mem [MAX_VERTICES];

  hcs_state_t state, state_next;

  logic [MAX_VERTICES-1:0] row_vld;
  logic [MAX_VERTICES-1:0] adj_rd;
  logic                    adj_ok;
  logic [VW-1:0]           path_rd;
  logic [NW-1:0]           cur_rd;

  logic [VW-1:0]           eu, ev, top;
  logic [NW-1:0]           cur, depth, pidx;
  logic [MAX_VERTICES-1:0] mask, row, start_row;
  logic [RW-1:0]           reports;
  logic                    found, ovf;
  logic [63:0]             word;

  logic [NW-1:0]           n;
  logic [NW-1:0]           dm1, dm2;
  logic [MAX_VERTICES-1:0] adj_row, cand;
  logic [VW-1:0]           nb;
  logic                    hit, leaf, close, acc, edge_ok, start_ok, do_pop, res_acc;

  logic                    adj_we, path_we, cur_we;
  logic [VW-1:0]           adj_waddr, adj_raddr, path_waddr, path_raddr, cur_waddr;
  logic [MAX_VERTICES-1:0] adj_wdata;
  logic [VW-1:0]           path_wdata;
  logic [NW-1:0]           cur_wdata;

  always_comb begin
    if (vertex_count == 5'd0) begin
      n = NW'(1);
    end else if (vertex_count > 5'(MAX_VERTICES)) begin
      n = NMAX;
    end else begin
      n = vertex_count[NW-1:0];
    end
  end

  assign adj_row  = adj_ok ? adj_rd : '0;
  assign dm1      = depth - NW'(1);
  assign dm2      = depth - NW'(2);
  assign cmd_ready = (state == ST_IDLE);
  assign acc      = cmd_valid && cmd_ready;
  assign edge_ok  = ({1'b0, cmd.edge_u} < 5'(MAX_VERTICES)) &&
                    ({1'b0, cmd.edge_v} < 5'(MAX_VERTICES));
  assign start_ok = {1'b0, cmd.start_vertex} < 5'(n);
  assign leaf     = depth >= n;
  assign close    = start_row[top];
  assign res_acc  = res_valid && res_ready;

  always_comb begin
    for (int v = 0; v < MAX_VERTICES; v++) begin
      cand[v] = row[v] && !mask[v] && (NW'(v) < n) && (NW'(v) >= cur);
    end
    nb  = '0;
    hit = 1'b0;
    for (int v = MAX_VERTICES - 1; v >= 0; v--) begin
      if (cand[v]) begin
        nb  = VW'(v);
        hit = 1'b1;
      end
    end
  end

  always_comb begin
    do_pop = 1'b0;
    if (state == ST_EXPAND) begin
      do_pop = leaf ? !close : !hit;
    end else if (state == ST_REPORT) begin
      do_pop = res_ready;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (acc) begin
          unique case (cmd.func)
            FUNC_ADD_EDGE: state_next = edge_ok ? ST_EDGE_RDU : ST_ACK;
            FUNC_CLEAR:    state_next = ST_ACK;
            FUNC_SEARCH:   state_next = start_ok ? ST_SRCH_RD : ST_FINISH;
            default:       state_next = ST_IDLE;
          endcase
        end
      end
      ST_EDGE_RDU:  state_next = ST_EDGE_WRU;
      ST_EDGE_WRU:  state_next = ST_EDGE_RDV;
      ST_EDGE_RDV:  state_next = ST_EDGE_WRV;
      ST_EDGE_WRV:  state_next = ST_ACK;
      ST_ACK:       state_next = res_ready ? ST_IDLE : ST_ACK;
      ST_SRCH_RD:   state_next = ST_SRCH_INIT;
      ST_SRCH_INIT: state_next = ST_EXPAND;
      ST_ROW_WAIT:  state_next = ST_EXPAND;
      ST_EXPAND: begin
        if (leaf && close) begin
          state_next = (reports >= RMAX) ? ST_FINISH : ST_PACK_RD;
        end else if (!leaf && hit) begin
          state_next = ST_ROW_WAIT;
        end else begin
          state_next = (depth == NW'(1)) ? ST_FINISH : ST_POP_WAIT;
        end
      end
      ST_POP_WAIT:  state_next = ST_ROW_WAIT;
      ST_PACK_RD:   state_next = ST_PACK_GET;
      ST_PACK_GET:  state_next = (pidx + NW'(1) == n) ? ST_REPORT : ST_PACK_RD;
      ST_REPORT: begin
        if (res_ready) begin
          state_next = (depth == NW'(1)) ? ST_FINISH : ST_POP_WAIT;
        end
      end
      ST_FINISH:    state_next = res_ready ? ST_IDLE : ST_FINISH;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    adj_we     = 1'b0;
    adj_waddr  = eu;
    adj_wdata  = adj_row;
    adj_raddr  = top;
    path_we    = 1'b0;
    path_waddr = depth[VW-1:0];
    path_wdata = nb;
    path_raddr = dm2[VW-1:0];
    cur_we     = 1'b0;
    cur_waddr  = dm1[VW-1:0];
    cur_wdata  = NW'(nb) + NW'(1);
    res_valid  = 1'b0;
    res        = '0;
    unique case (state)
      ST_EDGE_RDU: adj_raddr = eu;
      ST_EDGE_WRU: begin
        adj_we            = 1'b1;
        adj_waddr         = eu;
        adj_wdata         = adj_row;
        adj_wdata[ev]     = 1'b1;
      end
      ST_EDGE_RDV: adj_raddr = ev;
      ST_EDGE_WRV: begin
        adj_we            = 1'b1;
        adj_waddr         = ev;
        adj_wdata         = adj_row;
        adj_wdata[eu]     = 1'b1;
      end
      ST_ACK: begin
        res_valid = 1'b1;
        res.kind  = KIND_ACK;
        res.last  = 1'b1;
      end
      ST_SRCH_RD: begin
        path_we    = 1'b1;
        path_waddr = '0;
        path_wdata = top;
      end
      ST_EXPAND: begin
        if (!leaf && hit) begin
          adj_raddr = nb;
          path_we   = 1'b1;
          cur_we    = 1'b1;
        end
      end
      ST_POP_WAIT: adj_raddr = path_rd;
      ST_PACK_RD:  path_raddr = pidx[VW-1:0];
      ST_REPORT: begin
        res_valid      = 1'b1;
        res.kind       = KIND_CYCLE;
        res.cycle_path = word;
      end
      ST_FINISH: begin
        res_valid           = 1'b1;
        res.kind            = KIND_FINISH;
        res.any_found       = found;
        res.report_overflow = ovf;
        res.last            = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adj_we) begin
      adj_mem[adj_waddr] <= adj_wdata;
    end
    adj_rd <= adj_mem[adj_raddr];
    adj_ok <= row_vld[adj_raddr];
    if (path_we) begin
      path_mem[path_waddr] <= path_wdata;
    end
    path_rd <= path_mem[path_raddr];
    if (cur_we) begin
      cur_mem[cur_waddr] <= cur_wdata;
    end
    cur_rd <= cur_mem[dm2[VW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      row_vld <= '0;
    end else begin
      state <= state_next;
      if (acc && cmd.func == FUNC_CLEAR) begin
        row_vld <= '0;
      end
      if (adj_we) begin
        row_vld[adj_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      eu      <= cmd.edge_u[VW-1:0];
      ev      <= cmd.edge_v[VW-1:0];
      top     <= cmd.start_vertex[VW-1:0];
      cur     <= '0;
      depth   <= NW'(1);
      mask    <= MAX_VERTICES'(1) << cmd.start_vertex[VW-1:0];
      reports <= '0;
      found   <= 1'b0;
      ovf     <= 1'b0;
    end
    if (state == ST_SRCH_INIT) begin
      start_row <= adj_row;
      row       <= adj_row;
    end
    if (state == ST_ROW_WAIT) begin
      row <= adj_row;
    end
    if (state == ST_POP_WAIT) begin
      top <= path_rd;
      cur <= cur_rd;
    end
    if (state == ST_EXPAND) begin
      if (leaf && close) begin
        found <= 1'b1;
        if (reports >= RMAX) begin
          ovf <= 1'b1;
        end
        pidx <= '0;
        word <= '0;
      end else if (!leaf && hit) begin
        mask[nb] <= 1'b1;
        depth    <= depth + NW'(1);
        top      <= nb;
        cur      <= '0;
      end
    end
    if (state == ST_PACK_GET) begin
      word[pidx[VW-1:0] * 4 +: 4] <= 4'(path_rd);
      pidx <= pidx + NW'(1);
    end
    if (state == ST_REPORT && res_acc) begin
      reports <= reports + RW'(1);
    end
    if (do_pop) begin
      mask[top] <= 1'b0;
      depth     <= dm1;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/hamiltonian_cycle_search.sv -----
// Channel  Direction  Word
// cmd      in         func, edge_u, edge_v, start_vertex
// res      out        kind, cycle_path, any_found, report_overflow, last
// cfg      in         vertex_count, written when cfg_we is high
//
// An edge load reads and writes the rows of edge_u and edge_v in turn, then acknowledges;
// a clear empties the graph. A search steps forward or back and packs each reported cycle
// vertex by vertex; the number of steps depends on the graph and grows exponentially in n.
// Registered reads of the adjacency, path and cursor memories set the step time.
// Reset is synchronous and empties the graph at once through per-row valid bits.
// A stalled result word holds the engine; one word waits in the output register.
`default_nettype none
module hamiltonian_cycle_search
  import hcs_pkg::*;
#(
  parameter int MAX_VERTICES = HCS_MAX_VERTICES,
  parameter int MAX_REPORTS  = HCS_MAX_REPORTS
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [4:0] cfg_wdata,
  hcs_cmd_if.sink         cmd,
  hcs_res_if.source       res
);

  logic [4:0]  vertex_count;
  logic        eng_valid, eng_ready;
  hcs_cmd_t    eng_cmd;
  hcs_result_t eng_res, res_q;
  logic        res_vq;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= VCOUNT_RESET;
    end else if (cfg_we) begin
      vertex_count <= cfg_wdata;
    end
  end

  assign eng_cmd.func         = cmd.func;
  assign eng_cmd.edge_u       = cmd.edge_u;
  assign eng_cmd.edge_v       = cmd.edge_v;
  assign eng_cmd.start_vertex = cmd.start_vertex;

  hcs_engine #(
    .MAX_VERTICES(MAX_VERTICES),
    .MAX_REPORTS (MAX_REPORTS)
  ) u_engine (
    .clk         (clk),
    .rst         (rst),
    .vertex_count(vertex_count),
    .cmd_valid   (cmd.valid),
    .cmd_ready   (cmd.ready),
    .cmd         (eng_cmd),
    .res_valid   (eng_valid),
    .res_ready   (eng_ready),
    .res         (eng_res)
  );

  assign eng_ready = !res_vq || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_vq <= 1'b0;
    end else if (eng_ready) begin
      res_vq <= eng_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (eng_ready && eng_valid) begin
      res_q <= eng_res;
    end
  end

  assign res.valid           = res_vq;
  assign res.kind            = res_q.kind;
  assign res.cycle_path      = res_q.cycle_path;
  assign res.any_found       = res_q.any_found;
  assign res.report_overflow = res_q.report_overflow;
  assign res.last            = res_q.last;

endmodule
`default_nettype wire

// ----- rtl/hcs_check.sv -----
`default_nettype none
module hcs_check
  import hcs_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        res_valid,
  input wire logic        res_ready,
  input wire logic [1:0]  kind,
  input wire logic        any_found,
  input wire logic        report_overflow,
  input wire logic        last
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(kind) && $stable(last))
    else $error("result word changed while stalled");

  a_cycle_not_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && kind == KIND_CYCLE |-> !last)
    else $error("cycle word marked last");

  a_flags_only_finish: assert property (@(posedge clk) disable iff (rst)
    res_valid && kind != KIND_FINISH |-> !any_found && !report_overflow)
    else $error("status flags outside finish word");

  a_ovf_found: assert property (@(posedge clk) disable iff (rst)
    res_valid && kind == KIND_FINISH && report_overflow |-> any_found)
    else $error("overflow without any cycle found");

endmodule

bind hamiltonian_cycle_search hcs_check u_check (
  .clk            (clk),
  .rst            (rst),
  .res_valid      (res.valid),
  .res_ready      (res.ready),
  .kind           (res.kind),
  .any_found      (res.any_found),
  .report_overflow(res.report_overflow),
  .last           (res.last)
);
`default_nettype wire
